// ===== hdl/csb_pkg.sv =====
// Shared types and codes for the cursor sequence buffer.
package csb_pkg;

    localparam int KIND_BITS   = 3;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADVANCE = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_INSERT  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_ATTACH  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_REPORT  = 3'd5;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_ITEM = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [VALUE_BITS-1:0] entry_value;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  current_value;
        logic                   has_item;
        logic [COUNT_BITS-1:0]  item_count;
        logic [STATUS_BITS-1:0] status;
    } t_res;

endpackage

// ===== hdl/csb_if.sv =====
// Valid/ready channel interfaces for command and result beats.
interface csb_cmd_if
    import csb_pkg::*;
;
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface csb_res_if
    import csb_pkg::*;
;
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cursor_sequence_buffer.sv =====
// Cursor sequence buffer: ordered word list with cursor, held in one synchronous RAM.
//
//  channel  | dir | modport | payload
//  i_cmd    | in  | sink    | kind, entry_value
//  o_res    | out | source  | current_value, has_item, item_count, status
//
// Start, advance, report and refused commands pass through the execute, read and load states.
// Insert, attach and remove also shift the stored words (up to DEPTH-1) before the read:
// the single RAM read port and write port move one word per cycle.
// Reset clears state, count, cursor and the write and output valid flags; the RAM is not cleared.
// A finished result sits in the output register; the next command is taken meanwhile,
// and a new result waits in its last state until that register frees up.
module cursor_sequence_buffer
    import csb_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csb_cmd_if.sink          i_cmd,
    csb_res_if.source        o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_SHDN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_WRN   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_LD    = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_cur, n_cur;
    logic                   r_wv, n_wv;
    logic                   r_ov, n_ov;
    logic [AW-1:0]          r_wa, n_wa;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_end, n_end;
    logic [KIND_BITS-1:0]   r_kind, n_kind;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic                   r_hv, n_hv;
    t_res                   r_res, n_res;

    logic [WORD_BITS-1:0]   r_mem [DEPTH];
    logic [WORD_BITS-1:0]   r_q;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [AW-1:0]          mem_ra;
    logic [WORD_BITS-1:0]   mem_wd;

    logic                   cur_valid;
    logic                   is_full;
    logic                   out_free;
    logic [CW-1:0]          cnt_m1;
    logic [CW-1:0]          cur_p1;
    logic [WORD_BITS+VALUE_BITS-1:0] in_ext;
    logic [WORD_BITS+VALUE_BITS-1:0] q_ext;
    logic [CW+COUNT_BITS-1:0]        cnt_ext;

    assign cur_valid = (r_cur < r_cnt);
    assign is_full   = (r_cnt >= CW'(DEPTH));
    assign out_free  = !r_ov || o_res.ready;
    assign cnt_m1    = r_cnt - CW'(1);
    assign cur_p1    = r_cur + CW'(1);
    assign in_ext    = {{WORD_BITS{1'b0}}, i_cmd.data.entry_value};
    assign q_ext     = {{VALUE_BITS{1'b0}}, r_q};
    assign cnt_ext   = {{COUNT_BITS{1'b0}}, r_cnt};

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

    // RAM ports
    assign mem_we = r_wv || (r_state == S_WRN);
    assign mem_wa = r_wv ? r_wa : r_cur[AW-1:0];
    assign mem_wd = r_wv ? r_q : r_word;
    assign mem_ra = ((r_state == S_SHUP) || (r_state == S_SHDN)) ? r_idx : r_cur[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[mem_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_wv     = 1'b0;
        n_ov     = r_ov;
        n_wa     = r_wa;
        n_idx    = r_idx;
        n_end    = r_end;
        n_kind   = r_kind;
        n_word   = r_word;
        n_status = r_status;
        n_hv     = r_hv;
        n_res    = r_res;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_kind   = i_cmd.data.kind;
                    n_word   = in_ext[WORD_BITS-1:0];
                    n_status = STATUS_DONE;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RD;
                unique case (r_kind)
                    KIND_START: begin
                        n_cur = '0;
                    end
                    KIND_ADVANCE: begin
                        if (!cur_valid) begin
                            n_status = STATUS_NO_ITEM;
                        end else begin
                            n_cur = cur_p1;
                        end
                    end
                    KIND_INSERT: begin
                        if (is_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_cur = cur_valid ? r_cur : '0;
                            n_idx = cnt_m1[AW-1:0];
                            n_end = n_cur[AW-1:0];
                            n_state = (r_cnt == n_cur) ? S_WRN : S_SHUP;
                        end
                    end
                    KIND_ATTACH: begin
                        if (is_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_cur = cur_valid ? cur_p1 : r_cnt;
                            n_idx = cnt_m1[AW-1:0];
                            n_end = n_cur[AW-1:0];
                            n_state = (r_cnt == n_cur) ? S_WRN : S_SHUP;
                        end
                    end
                    KIND_REMOVE: begin
                        if (!cur_valid) begin
                            n_status = STATUS_NO_ITEM;
                        end else begin
                            n_idx = cur_p1[AW-1:0];
                            n_end = cnt_m1[AW-1:0];
                            n_state = (cur_p1 == r_cnt) ? S_DRAIN : S_SHDN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHUP: begin
                n_wv = 1'b1;
                n_wa = r_idx + AW'(1);
                if (r_idx == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            S_SHDN: begin
                n_wv = 1'b1;
                n_wa = r_idx - AW'(1);
                if (r_idx == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                if (r_kind == KIND_REMOVE) begin
                    n_cnt = cnt_m1;
                    if (cnt_m1 == '0) begin
                        n_cur = '0;
                    end
                    n_state = S_RD;
                end else begin
                    n_state = S_WRN;
                end
            end
            S_WRN: begin
                n_cnt   = r_cnt + CW'(1);
                n_state = S_RD;
            end
            S_RD: begin
                n_hv    = cur_valid;
                n_state = S_LD;
            end
            S_LD: begin
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_res.current_value = r_hv ? q_ext[VALUE_BITS-1:0] : '0;
                    n_res.has_item      = r_hv;
                    n_res.item_count    = cnt_ext[COUNT_BITS-1:0];
                    n_res.status        = r_status;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cur   <= n_cur;
            r_wv    <= n_wv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa     <= n_wa;
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_kind   <= n_kind;
        r_word   <= n_word;
        r_status <= n_status;
        r_hv     <= n_hv;
        r_res    <= n_res;
    end

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_cnt)
        else $error("cursor beyond count");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("count beyond depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ({1'b0, mem_wa} <= {1'b0, r_cnt}))
        else $error("RAM write past list end");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD && out_free) |=> (r_ov && r_state == S_IDLE))
        else $error("result not loaded");

endmodule

// ===== bench/cursor_sequence_buffer_tb.sv =====
`timescale 1ns / 1ps
// Cursor sequence buffer self-checking testbench: directed and random beats against a list model.
module cursor_sequence_buffer_tb
    import csb_pkg::*;
;

    localparam int DEPTH        = 64;
    localparam int WORD_BITS    = 32;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 80;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;

    // unused kind codes, decoded as report
    localparam logic [KIND_BITS-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE7 = 3'd7;

    typedef struct {
        t_cmd cmd;
        bit   after_drain;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    csb_cmd_if cmd_if ();
    csb_res_if res_if ();

    cursor_sequence_buffer #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pending cmd_queue[$];
    t_res     expected_q[$];

    logic [VALUE_BITS-1:0] list_words [DEPTH];
    int list_len = 0;
    int list_pos = 0;

    int  errors        = 0;
    int  cycle_count   = 0;
    int  cmds_accepted = 0;
    bit  cmd_accepted  = 1'b0;
    int  send_gap      = 0;
    int  recv_gap      = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    // Apply one command to the list model and return the result it produces.
    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        logic [STATUS_BITS-1:0] st;
        int i;
        st = STATUS_DONE;
        case (c.kind)
            KIND_START: begin
                list_pos = 0;
            end
            KIND_ADVANCE: begin
                if (list_pos < list_len) list_pos++;
                else st = STATUS_NO_ITEM;
            end
            KIND_INSERT: begin
                if (list_len >= DEPTH) begin
                    st = STATUS_FULL;
                end else begin
                    if (list_pos >= list_len) list_pos = 0;
                    for (i = list_len; i > list_pos; i--) list_words[i] = list_words[i-1];
                    list_words[list_pos] = c.entry_value;
                    list_len++;
                end
            end
            KIND_ATTACH: begin
                if (list_len >= DEPTH) begin
                    st = STATUS_FULL;
                end else begin
                    if (list_pos >= list_len) begin
                        list_pos = list_len;
                    end else begin
                        for (i = list_len; i > list_pos + 1; i--) list_words[i] = list_words[i-1];
                        list_pos++;
                    end
                    list_words[list_pos] = c.entry_value;
                    list_len++;
                end
            end
            KIND_REMOVE: begin
                if (list_pos >= list_len) begin
                    st = STATUS_NO_ITEM;
                end else begin
                    for (i = list_pos + 1; i < list_len; i++) list_words[i-1] = list_words[i];
                    list_len--;
                    if (list_len == 0) list_pos = 0;
                end
            end
            default: ;
        endcase
        r.has_item      = (list_pos < list_len);
        r.current_value = r.has_item ? list_words[list_pos] : '0;
        r.item_count    = list_len[COUNT_BITS-1:0];
        r.status        = st;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if ((cycle_count / 600) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Weighted pick: insert, attach, remove by weight, the rest spread over the other kinds.
    function automatic logic [KIND_BITS-1:0] pick_kind(int w_ins, int w_att, int w_rem);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins) return KIND_INSERT;
        if (r < w_ins + w_att) return KIND_ATTACH;
        if (r < w_ins + w_att + w_rem) return KIND_REMOVE;
        case ($urandom_range(0, 5))
            0: return KIND_START;
            1: return KIND_REPORT;
            2: return KIND_SPARE6;
            3: return KIND_SPARE7;
            default: return KIND_ADVANCE;
        endcase
    endfunction

    task automatic add_cmd(logic [KIND_BITS-1:0] kind, logic [VALUE_BITS-1:0] value,
                           bit after_drain);
        t_pending p;
        p.cmd.kind        = kind;
        p.cmd.entry_value = value;
        p.after_drain     = after_drain;
        cmd_queue.push_back(p);
    endtask

    task automatic add_phase(int n, int w_ins, int w_att, int w_rem);
        int k;
        for (k = 0; k < n; k++) add_cmd(pick_kind(w_ins, w_att, w_rem), pick_word(), k == 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[cursor_sequence_buffer] ERROR");
            $finish;
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin : watch
        t_res want;
        t_res got;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_q.push_back(apply_cmd(cmd_if.data));
                cmds_accepted++;
                cmd_accepted = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat: %p", got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.current_value !== want.current_value) begin
                        $error("current_value: expected %h, got %h",
                               want.current_value, got.current_value);
                        errors++;
                    end
                    if (got.has_item !== want.has_item) begin
                        $error("has_item: expected %b, got %b", want.has_item, got.has_item);
                        errors++;
                    end
                    if (got.item_count !== want.item_count) begin
                        $error("item_count: expected %0d, got %0d",
                               want.item_count, got.item_count);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
        end
    end

    // Command driver.
    always @(negedge i_clk) begin : drive_cmd
        t_pending p;
        bit offer;
        offer = 1'b0;
        if (i_rst_n && (!cmd_if.valid || cmd_accepted)) begin
            cmd_accepted = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (cmd_queue.size() > 0 &&
                         (!cmd_queue[0].after_drain || expected_q.size() == 0)) begin
                p        = cmd_queue.pop_front();
                offer    = 1'b1;
                send_gap = pick_gap();
                cmd_if.data <= p.cmd;
            end
            cmd_if.valid <= offer;
        end
    end

    // Result backpressure, with one long hold-off to fill the block.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && cmds_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;

        // directed: empty list, front/back placement, walking off the end, removals
        add_cmd(KIND_REPORT,  32'h0000_0000, 1'b0);
        add_cmd(KIND_ADVANCE, 32'h0000_0000, 1'b0);
        add_cmd(KIND_REMOVE,  32'h0000_0000, 1'b0);
        add_cmd(KIND_START,   32'h0000_0000, 1'b0);
        add_cmd(KIND_INSERT,  32'hFFFF_FFFF, 1'b0);
        add_cmd(KIND_ATTACH,  32'h0000_0000, 1'b0);
        add_cmd(KIND_ADVANCE, 32'hFFFF_FFFF, 1'b0);
        add_cmd(KIND_ATTACH,  32'h1234_5678, 1'b0);
        add_cmd(KIND_START,   32'h0000_0000, 1'b0);
        add_cmd(KIND_INSERT,  32'hA5A5_A5A5, 1'b0);
        add_cmd(KIND_ADVANCE, 32'h0000_0000, 1'b0);
        add_cmd(KIND_ADVANCE, 32'h0000_0000, 1'b0);
        add_cmd(KIND_REMOVE,  32'h0000_0000, 1'b0);
        add_cmd(KIND_REMOVE,  32'h0000_0000, 1'b0);
        add_cmd(KIND_ADVANCE, 32'h0000_0000, 1'b0);
        add_cmd(KIND_SPARE6,  32'h5A5A_5A5A, 1'b0);
        add_cmd(KIND_SPARE7,  32'hFFFF_FFFF, 1'b0);
        add_cmd(KIND_START,   32'h0000_0000, 1'b0);
        add_cmd(KIND_REMOVE,  32'h0000_0000, 1'b0);
        add_cmd(KIND_REMOVE,  32'h0000_0000, 1'b0);
        add_cmd(KIND_REPORT,  32'h0000_0000, 1'b0);
        add_cmd(KIND_INSERT,  32'h8000_0000, 1'b0);
        add_cmd(KIND_ATTACH,  32'h0000_0001, 1'b0);
        add_cmd(KIND_REPORT,  32'h0000_0000, 1'b0);

        // random: fill to full, mix, drain, refill
        add_phase(100, 40, 40, 4);
        add_phase(150, 17, 17, 17);
        add_phase(100, 5, 5, 55);
        add_phase(100, 40, 40, 4);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_queue.size() != 0 || cmd_if.valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_q.size() == 0) begin
            $display("[cursor_sequence_buffer] OK");
        end else begin
            $display("[cursor_sequence_buffer] ERROR");
        end
        $finish;
    end

endmodule

// ===== cursor_sequence_buffer.f =====
hdl/csb_pkg.sv
hdl/csb_if.sv
hdl/cursor_sequence_buffer.sv
bench/cursor_sequence_buffer_tb.sv
